// File: hdl/nhe_pkg.sv
// nhe_pkg: shared types and constants of the nand hamming ecc generator/checker
// used by the front, queue, back and top modules; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nhe_pkg;

    localparam int unsigned ECC_W      = 24;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BIT_IDX_W  = 3;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [BYTE_W-1:0] LAST_POS = 8'hff;

    localparam logic KIND_GEN   = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DATA_BIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CODE_BIT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNCORR   = 2'd3;

    localparam logic [BYTE_W-1:0] PAIR_MASK    = 8'h55;
    localparam logic [BYTE_W-1:0] PAIR_MASK_CP = 8'h54;

    typedef struct packed {
        logic             kind;
        logic [ECC_W-1:0] ecc;
        logic [ECC_W-1:0] diff;
    } t_entry;

endpackage : nhe_pkg

`default_nettype wire

// File: hdl/nand_hamming_ecc_gen_check_top.sv
// nand_hamming_ecc_gen_check_top: 256-byte nand block hamming ecc generator and checker
// path: a result is pushed from the front into the queue, then registered in the back output register
// throughput: one beat per cycle; ready drops only when the result queue is full
// reset: synchronous active low; clears parity accumulators, byte position and kept code
// depends on nhe_pkg, nhe_front, nhe_queue, nhe_back
`timescale 1ns / 1ps
`default_nettype none

module nand_hamming_ecc_gen_check_top
    import nhe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // data_byte, stored_ecc
    input  wire logic                  s_axis_tuser,   // req_type
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // ecc_value, status, error_byte_index, error_bit_index
    output logic                       m_axis_tuser    // result_kind
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry entry;
    t_entry head;

    nhe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_req_type   (s_axis_tuser),
        .i_data_byte  (s_axis_tdata[7:0]),
        .i_stored_ecc (s_axis_tdata[31:8]),
        .i_full       (full),
        .o_ready      (s_axis_tready),
        .o_push       (push),
        .o_entry      (entry)
    );

    nhe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    nhe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule : nand_hamming_ecc_gen_check_top

`default_nettype wire

// File: hdl/nhe_front.sv
// nhe_front: accepts beats, accumulates column and line parity, forms the code
// at block end and turns check requests into code differences; uses nhe_pkg
`timescale 1ns / 1ps
`default_nettype none

module nhe_front
    import nhe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_req_type,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [ECC_W-1:0]  i_stored_ecc,
    input  wire logic              i_full,
    output logic                   o_ready,
    output logic                   o_push,
    output t_entry                 o_entry
);

    logic [5:0]        r_cp;
    logic [BYTE_W-1:0] r_lpt;
    logic [BYTE_W-1:0] r_lpc;
    logic [BYTE_W-1:0] r_pos;
    logic [ECC_W-1:0]  r_kept;

    logic [5:0]        n_cp;
    logic [BYTE_W-1:0] n_lpt;
    logic [BYTE_W-1:0] n_lpc;
    logic [5:0]        col_bits;
    logic              byte_par;
    logic              accept;
    logic              is_last;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [ECC_W-1:0]  code;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign is_last = (r_pos == LAST_POS);

    always_comb begin
        col_bits[0] = ^(i_data_byte & 8'h55);
        col_bits[1] = ^(i_data_byte & 8'haa);
        col_bits[2] = ^(i_data_byte & 8'h33);
        col_bits[3] = ^(i_data_byte & 8'hcc);
        col_bits[4] = ^(i_data_byte & 8'h0f);
        col_bits[5] = ^(i_data_byte & 8'hf0);
        byte_par    = ^i_data_byte;
        n_cp  = r_cp ^ col_bits;
        n_lpt = byte_par ? (r_lpt ^ r_pos) : r_lpt;
        n_lpc = byte_par ? (r_lpc ^ ~r_pos) : r_lpc;
        b0 = ~{n_lpt[7], n_lpc[7], n_lpt[6], n_lpc[6],
               n_lpt[5], n_lpc[5], n_lpt[4], n_lpc[4]};
        b1 = ~{n_lpt[3], n_lpc[3], n_lpt[2], n_lpc[2],
               n_lpt[1], n_lpc[1], n_lpt[0], n_lpc[0]};
        b2 = {~n_cp, 2'b11};
        code = {b2, b1, b0};
    end

    always_comb begin
        o_push = accept && (i_req_type || is_last);
        if (i_req_type) begin
            o_entry.kind = KIND_CHECK;
            o_entry.ecc  = r_kept;
            o_entry.diff = r_kept ^ i_stored_ecc;
        end else begin
            o_entry.kind = KIND_GEN;
            o_entry.ecc  = code;
            o_entry.diff = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp   <= '0;
            r_lpt  <= '0;
            r_lpc  <= '0;
            r_pos  <= '0;
            r_kept <= '0;
        end else if (accept && !i_req_type) begin
            r_pos <= r_pos + 1'b1;
            if (is_last) begin
                r_cp   <= '0;
                r_lpt  <= '0;
                r_lpc  <= '0;
                r_kept <= code;
            end else begin
                r_cp  <= n_cp;
                r_lpt <= n_lpt;
                r_lpc <= n_lpc;
            end
        end
    end

endmodule : nhe_front

`default_nettype wire

// File: hdl/nhe_queue.sv
// nhe_queue: small fifo of pending results between front and back
// uses nhe_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module nhe_queue
    import nhe_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_entry    i_entry,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_entry    o_head
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_entry         r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule : nhe_queue

`default_nettype wire

// File: hdl/nhe_back.sv
// nhe_back: decodes code differences into check status and holds the output beat
// uses nhe_pkg
`timescale 1ns / 1ps
`default_nettype none

module nhe_back
    import nhe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_empty,
    input  t_entry                     i_head,
    output logic                       o_pop,
    input  wire logic                  i_tready,
    output logic                       o_tvalid,
    output logic [OUT_DATA_W-1:0]      o_tdata,
    output logic                       o_tuser
);

    logic                   r_valid;
    logic                   r_kind;
    logic [ECC_W-1:0]       r_ecc;
    logic [STATUS_W-1:0]    r_status;
    logic [BYTE_W-1:0]      r_byte_idx;
    logic [BIT_IDX_W-1:0]   r_bit_idx;

    logic [BYTE_W-1:0]      d1;
    logic [BYTE_W-1:0]      d2;
    logic [BYTE_W-1:0]      d3;
    logic                   pairs_ok;
    logic                   one_bit;
    logic [STATUS_W-1:0]    n_status;
    logic [BYTE_W-1:0]      n_byte_idx;
    logic [BIT_IDX_W-1:0]   n_bit_idx;

    assign o_pop = !i_empty && (!r_valid || i_tready);

    always_comb begin
        d1 = i_head.diff[7:0];
        d2 = i_head.diff[15:8];
        d3 = i_head.diff[23:16];
        pairs_ok = (((d1 ^ (d1 >> 1)) & PAIR_MASK) == PAIR_MASK)
                && (((d2 ^ (d2 >> 1)) & PAIR_MASK) == PAIR_MASK)
                && (((d3 ^ (d3 >> 1)) & PAIR_MASK_CP) == PAIR_MASK_CP);
        one_bit  = ((i_head.diff & (i_head.diff - 1'b1)) == '0);
        n_byte_idx = '0;
        n_bit_idx  = '0;
        if (i_head.kind == KIND_GEN || i_head.diff == '0) begin
            n_status = ST_OK;
        end else if (pairs_ok) begin
            n_status   = ST_DATA_BIT;
            n_byte_idx = {d1[7], d1[5], d1[3], d1[1], d2[7], d2[5], d2[3], d2[1]};
            n_bit_idx  = {d3[7], d3[5], d3[3]};
        end else if (one_bit) begin
            n_status = ST_CODE_BIT;
        end else begin
            n_status = ST_UNCORR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind     <= i_head.kind;
            r_ecc      <= i_head.ecc;
            r_status   <= n_status;
            r_byte_idx <= n_byte_idx;
            r_bit_idx  <= n_bit_idx;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_kind;
    assign o_tdata  = {3'b000, r_bit_idx, r_byte_idx, r_status, r_ecc};

endmodule : nhe_back

`default_nettype wire

// File: tb/sv/tb_nand_hamming_ecc_gen_check_top.sv
// tb_nand_hamming_ecc_gen_check_top: self-checking bench for the 256-byte nand hamming ecc block
// streams data and check beats with random gaps, predicts each result beat, compares field by field
// depends on nhe_pkg and nand_hamming_ecc_gen_check_top
`timescale 1ns / 1ps

module tb_nand_hamming_ecc_gen_check_top;
    import nhe_pkg::*;

    typedef struct packed {
        logic                 kind;
        logic [ECC_W-1:0]     ecc;
        logic [STATUS_W-1:0]  status;
        logic [BYTE_W-1:0]    byte_idx;
        logic [BIT_IDX_W-1:0] bit_idx;
    } ecc_result_t;

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // data_byte, stored_ecc
    logic                  s_axis_tuser;   // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // ecc_value, status, error_byte_index, error_bit_index
    logic                  m_axis_tuser;   // result_kind

    // model state
    logic [5:0]        col_acc;
    logic [7:0]        lp_true;
    logic [7:0]        lp_compl;
    logic [7:0]        byte_pos;
    logic [ECC_W-1:0]  kept_code;

    ecc_result_t       ecc_results_due[$];
    int unsigned       error_count;
    int unsigned       beats_sent;
    logic              burst_mode;

    nand_hamming_ecc_gen_check_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_nand_hamming_ecc_gen_check_top: done, errors");
        $finish;
    end

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode) return 0;
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    task automatic predict_ecc_result(input logic req, input logic [7:0] data,
                                      input logic [ECC_W-1:0] stored);
        ecc_result_t      res;
        logic [5:0]       cp;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       d1;
        logic [7:0]       d2;
        logic [7:0]       d3;
        logic [ECC_W-1:0] diff;
        int               k;
        res = '0;
        if (req == REQ_DATA) begin
            cp[0] = ^(data & 8'h55);
            cp[1] = ^(data & 8'haa);
            cp[2] = ^(data & 8'h33);
            cp[3] = ^(data & 8'hcc);
            cp[4] = ^(data & 8'h0f);
            cp[5] = ^(data & 8'hf0);
            col_acc = col_acc ^ cp;
            if (^data) begin
                lp_true  = lp_true ^ byte_pos;
                lp_compl = lp_compl ^ ~byte_pos;
            end
            if (byte_pos == LAST_POS) begin
                b0 = '0;
                b1 = '0;
                for (k = 0; k < 4; k++) begin
                    b0[7-2*k] = lp_true[7-k];
                    b0[6-2*k] = lp_compl[7-k];
                    b1[7-2*k] = lp_true[3-k];
                    b1[6-2*k] = lp_compl[3-k];
                end
                kept_code = {~col_acc, 2'b11, ~b1, ~b0};
                col_acc  = '0;
                lp_true  = '0;
                lp_compl = '0;
                res.kind = KIND_GEN;
                res.ecc  = kept_code;
                ecc_results_due.push_back(res);
            end
            byte_pos = byte_pos + 8'd1;
        end else begin
            diff = kept_code ^ stored;
            d1 = diff[7:0];
            d2 = diff[15:8];
            d3 = diff[23:16];
            res.kind = KIND_CHECK;
            res.ecc  = kept_code;
            if (diff == '0) begin
                res.status = ST_OK;
            end else if (((d1 ^ (d1 >> 1)) & PAIR_MASK) == PAIR_MASK &&
                         ((d2 ^ (d2 >> 1)) & PAIR_MASK) == PAIR_MASK &&
                         ((d3 ^ (d3 >> 1)) & PAIR_MASK_CP) == PAIR_MASK_CP) begin
                res.status = ST_DATA_BIT;
                for (k = 0; k < 4; k++) begin
                    res.byte_idx[7-k] = d1[7-2*k];
                    res.byte_idx[3-k] = d2[7-2*k];
                end
                for (k = 0; k < 3; k++) res.bit_idx[2-k] = d3[7-2*k];
            end else if ($countones(diff) == 1) begin
                res.status = ST_CODE_BIT;
            end else begin
                res.status = ST_UNCORR;
            end
            ecc_results_due.push_back(res);
        end
    endtask

    task automatic send_beat(input logic req, input logic [7:0] data,
                             input logic [ECC_W-1:0] stored);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {stored, data};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_ecc_result(req, data, stored);
        beats_sent++;
        @(negedge i_clk);
        gap = idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= $urandom;
            s_axis_tdata  <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_check(input logic [ECC_W-1:0] stored);
        send_beat(REQ_CHECK, $urandom, stored);
    endtask

    // code difference that a single flipped data bit produces
    function automatic logic [ECC_W-1:0] data_flip_syndrome(input logic [7:0] byte_idx,
                                                            input logic [2:0] bit_idx);
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;
        int         k;
        s0 = '0;
        s1 = '0;
        s2 = '0;
        for (k = 0; k < 4; k++) begin
            s0[7-2*k] = byte_idx[7-k];
            s0[6-2*k] = ~byte_idx[7-k];
            s1[7-2*k] = byte_idx[3-k];
            s1[6-2*k] = ~byte_idx[3-k];
        end
        for (k = 0; k < 3; k++) begin
            s2[7-2*k] = bit_idx[2-k];
            s2[6-2*k] = ~bit_idx[2-k];
        end
        return {s2, s1, s0};
    endfunction

    function automatic logic [ECC_W-1:0] random_check_code();
        int unsigned a;
        int unsigned b;
        a = $urandom_range(0, ECC_W-1);
        b = (a + $urandom_range(1, ECC_W-1)) % ECC_W;
        case ($urandom_range(0, 4))
            0: return kept_code;
            1: return kept_code ^ (24'h1 << a);
            2: return kept_code ^ data_flip_syndrome($urandom, $urandom);
            3: return $urandom;
            default: return kept_code ^ (24'h1 << a) ^ (24'h1 << b);
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [ECC_W-1:0] got,
                                   input logic [ECC_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        ecc_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ecc_results_due.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[ECC_W-1:0], '0);
            end else begin
                want = ecc_results_due.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("result_kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[23:0] !== want.ecc)
                    report_mismatch("ecc_value", m_axis_tdata[23:0], want.ecc);
                if (m_axis_tdata[25:24] !== want.status)
                    report_mismatch("status", m_axis_tdata[25:24], want.status);
                if (m_axis_tdata[33:26] !== want.byte_idx)
                    report_mismatch("error_byte_index", m_axis_tdata[33:26], want.byte_idx);
                if (m_axis_tdata[36:34] !== want.bit_idx)
                    report_mismatch("error_bit_index", m_axis_tdata[36:34], want.bit_idx);
                if (m_axis_tdata[39:37] !== 3'b000)
                    report_mismatch("tdata padding", m_axis_tdata[39:37], '0);
            end
        end
    end

    initial begin
        int unsigned on_len;
        int unsigned off_len;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            on_len = $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (on_len) @(negedge i_clk);
            off_len = idle_cycles();
            if (off_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (off_len) @(negedge i_clk);
            end
        end
    end

    // kept code is zero after reset
    task automatic test_checks_after_reset();
        send_check(24'h000000);
        send_check(24'h000001);
        send_check(24'h800000);
        send_check(data_flip_syndrome(8'h00, 3'd0));
        send_check(data_flip_syndrome(8'hff, 3'd7));
        send_check(data_flip_syndrome(8'h5a, 3'd3));
        send_check(24'hffffff);
        send_check(24'h000003);
        send_check(24'h030000);
    endtask

    // all-zero or all-one block with a check in mid-block
    task automatic test_constant_blocks();
        logic [7:0]       fill;
        logic [ECC_W-1:0] prev_code;
        int               i;
        fill = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
        prev_code = kept_code;
        for (i = 0; i < 256; i++) begin
            if (i == 100) send_check(prev_code ^ data_flip_syndrome(8'h80, 3'd1));
            send_beat(REQ_DATA, fill, $urandom);
        end
        send_check(kept_code);
        send_check(kept_code ^ data_flip_syndrome(8'hff, 3'd0));
        send_check(kept_code ^ data_flip_syndrome(8'h00, 3'd7));
        send_check(kept_code ^ 24'h010000);
        send_check(~kept_code);
    endtask

    task automatic test_random_traffic();
        int unsigned mode;
        logic [7:0]  fixed_val;
        logic [7:0]  data;
        int          i;
        while (beats_sent < 400) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 2);
            fixed_val = $urandom;
            for (i = 0; i < 256; i++) begin
                if ($urandom_range(0, 63) == 0) send_check(random_check_code());
                case (mode)
                    0: data = $urandom;
                    1: data = ($urandom_range(0, 7) == 0) ? $urandom : 8'h00;
                    default: data = fixed_val;
                endcase
                send_beat(REQ_DATA, data, $urandom);
            end
            repeat ($urandom_range(50, 90)) send_check(random_check_code());
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        burst_mode    = 1'b0;
        error_count   = 0;
        beats_sent    = 0;
        col_acc       = '0;
        lp_true       = '0;
        lp_compl      = '0;
        byte_pos      = '0;
        kept_code     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_checks_after_reset();
        test_constant_blocks();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (ecc_results_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_nand_hamming_ecc_gen_check_top: done, clean");
        end else begin
            $display("tb_nand_hamming_ecc_gen_check_top: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/nhe_pkg.sv
hdl/nhe_front.sv
hdl/nhe_queue.sv
hdl/nhe_back.sv
hdl/nand_hamming_ecc_gen_check_top.sv
tb/sv/tb_nand_hamming_ecc_gen_check_top.sv
